[hw/rtl/l2h_pkg.sv]
// ============================================================================
// l2h_pkg
// Shared constants and command types for the streaming lookup2 string hash.
// ============================================================================
package l2h_pkg;

    // Start value of the three mixing words.
    localparam logic [31:0] GOLDEN_START = 32'h9e3779b9;

    // Bytes held back in the front end before a block is complete.
    localparam int TAIL_MAX = 11;

    // Work that the front end hands to the mixing core.
    typedef enum logic [1:0] {
        CMD_BLOCK,          // add a full block, then mix
        CMD_FINAL,          // add the tail and the length, then mix and emit
        CMD_BLOCK_FINAL     // add a full block, mix, add the length, mix and emit
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] key_len;
    } cmd_t;

endpackage

[hw/rtl/l2h_front.sv]
// ============================================================================
// l2h_front
// Byte packer. Collects key bytes into 12-byte blocks, counts the key length
// and issues block and key-end commands to the command queue.
// ============================================================================
module l2h_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                byte_present,
    input  logic                last,
    input  logic                queue_full,
    output logic                cmd_push,
    output l2h_pkg::cmd_t       cmd_data
);

    localparam logic [3:0] TAIL_POS = 4'(l2h_pkg::TAIL_MAX);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic [7:0]  bytes_reg [0:l2h_pkg::TAIL_MAX-1];

    logic        accept;
    logic        full_block;
    logic [3:0]  fill;
    logic [31:0] len_plus;
    logic [7:0]  cur_bytes  [0:l2h_pkg::TAIL_MAX-1];
    logic [7:0]  tail_bytes [0:l2h_pkg::TAIL_MAX-1];

    always_comb
    begin
        accept     = in_valid && !queue_full;
        in_stall   = queue_full;
        full_block = byte_present && (pos_reg == TAIL_POS);
        fill       = pos_reg + {3'b000, byte_present};
        len_plus   = len_reg + {31'd0, byte_present};

        for (int i = 0; i < l2h_pkg::TAIL_MAX; i++)
        begin
            cur_bytes[i] = (byte_present && (pos_reg == 4'(i))) ? data_byte : bytes_reg[i];
            // Positions past the end of the tail may still hold bytes of an earlier key.
            tail_bytes[i] = (4'(i) < fill) ? cur_bytes[i] : 8'h00;
        end

        cmd_data.key_len = len_plus;
        if (full_block)
        begin
            cmd_data.kind   = last ? l2h_pkg::CMD_BLOCK_FINAL : l2h_pkg::CMD_BLOCK;
            cmd_data.word_a = {cur_bytes[3], cur_bytes[2], cur_bytes[1], cur_bytes[0]};
            cmd_data.word_b = {cur_bytes[7], cur_bytes[6], cur_bytes[5], cur_bytes[4]};
            cmd_data.word_c = {data_byte, cur_bytes[10], cur_bytes[9], cur_bytes[8]};
        end
        else
        begin
            // In the tail the low byte of c is left free for the length.
            cmd_data.kind   = l2h_pkg::CMD_FINAL;
            cmd_data.word_a = {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]};
            cmd_data.word_b = {tail_bytes[7], tail_bytes[6], tail_bytes[5], tail_bytes[4]};
            cmd_data.word_c = {tail_bytes[10], tail_bytes[9], tail_bytes[8], 8'h00};
        end

        cmd_push = accept && (full_block || last);

        pos_next = pos_reg;
        len_next = len_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next = 4'd0;
                len_next = 32'd0;
            end
            else
            begin
                pos_next = full_block ? 4'd0 : fill;
                len_next = len_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            len_reg <= 32'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_present && !full_block)
        begin
            bytes_reg[pos_reg] <= data_byte;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= TAIL_POS)
        else $error("front: block position out of range");

    a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == 4'd0 && len_reg == 32'd0))
        else $error("front: key state not cleared after key end");
`endif

endmodule

[hw/rtl/l2h_cmd_fifo.sv]
// ============================================================================
// l2h_cmd_fifo
// Small command queue between the byte packer and the mixing core.
// ============================================================================
module l2h_cmd_fifo #(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  l2h_pkg::cmd_t   push_data,
    output logic            full,
    input  logic            pop,
    output l2h_pkg::cmd_t   pop_data,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    l2h_pkg::cmd_t   mem_reg [0:DEPTH-1];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        full     = (count_reg == FULL_CNT);
        empty    = (count_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("cmd queue: occupancy exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("cmd queue: push while full");
`endif

endmodule

[hw/rtl/l2h_mix_core.sv]
// ============================================================================
// l2h_mix_core
// Mixing core. Adds block and tail words into a, b and c, mixes one round per
// cycle (the last waits while a hash is unread), and registers the output hash.
// ============================================================================
module l2h_mix_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  l2h_pkg::cmd_t   cmd_data,
    output logic            cmd_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     hash_value
);

    localparam int         MIX_STEPS = 9;
    localparam logic [3:0] MIX_LAST  = 4'(MIX_STEPS - 1);

    typedef enum logic {
        S_IDLE,
        S_MIX
    } state_t;

    typedef enum logic [1:0] {
        TGT_A,
        TGT_B,
        TGT_C
    } mix_target_t;

    // The nine rounds update a, b, c in turn.
    function automatic mix_target_t mix_target(input logic [3:0] step);
        mix_target_t t;
        unique case (step)
            4'd0, 4'd3, 4'd6: t = TGT_A;
            4'd1, 4'd4, 4'd7: t = TGT_B;
            default:          t = TGT_C;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] mix_shift(input logic [3:0] step);
        logic [4:0] s;
        unique case (step)
            4'd0:    s = 5'd13;
            4'd1:    s = 5'd8;
            4'd2:    s = 5'd13;
            4'd3:    s = 5'd12;
            4'd4:    s = 5'd16;
            4'd5:    s = 5'd5;
            4'd6:    s = 5'd3;
            4'd7:    s = 5'd10;
            default: s = 5'd15;
        endcase
        return s;
    endfunction

    state_t      state_reg;
    state_t      state_next;
    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [31:0] b_reg;
    logic [31:0] b_next;
    logic [31:0] c_reg;
    logic [31:0] c_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic        final_after_reg;
    logic        final_after_next;
    logic        emit_reg;
    logic        emit_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] rc;
    logic [4:0]  sh;
    logic        last_step;
    logic        out_free;

    always_comb
    begin
        sh = mix_shift(step_reg);
        ra = a_reg;
        rb = b_reg;
        rc = c_reg;
        unique case (mix_target(step_reg))
            TGT_A:   ra = (a_reg - b_reg - c_reg) ^ (c_reg >> sh);
            TGT_B:   rb = (b_reg - c_reg - a_reg) ^ (a_reg << sh);
            default: rc = (c_reg - a_reg - b_reg) ^ (b_reg >> sh);
        endcase

        last_step = (step_reg == MIX_LAST);
        out_free  = !out_valid_reg || !out_stall;
        cmd_pop   = (state_reg == S_IDLE) && cmd_valid;

        state_next       = state_reg;
        step_next        = step_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        c_next           = c_reg;
        len_next         = len_reg;
        final_after_next = final_after_reg;
        emit_next        = emit_reg;
        hash_next        = hash_reg;
        out_valid_next   = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    a_next           = a_reg + cmd_data.word_a;
                    b_next           = b_reg + cmd_data.word_b;
                    c_next           = c_reg + cmd_data.word_c
                                     + ((cmd_data.kind == l2h_pkg::CMD_FINAL)
                                        ? cmd_data.key_len : 32'd0);
                    len_next         = cmd_data.key_len;
                    final_after_next = (cmd_data.kind == l2h_pkg::CMD_BLOCK_FINAL);
                    emit_next        = (cmd_data.kind != l2h_pkg::CMD_BLOCK);
                    step_next        = 4'd0;
                    state_next       = S_MIX;
                end
            end
            default:
            begin
                if (!last_step)
                begin
                    a_next    = ra;
                    b_next    = rb;
                    c_next    = rc;
                    step_next = step_reg + 4'd1;
                end
                else if (final_after_reg)
                begin
                    // Block ended exactly on the key end: an empty tail follows.
                    a_next           = ra;
                    b_next           = rb;
                    c_next           = rc + len_reg;
                    step_next        = 4'd0;
                    final_after_next = 1'b0;
                end
                else if (!emit_reg)
                begin
                    a_next     = ra;
                    b_next     = rb;
                    c_next     = rc;
                    step_next  = 4'd0;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    hash_next      = rc;
                    out_valid_next = 1'b1;
                    a_next         = l2h_pkg::GOLDEN_START;
                    b_next         = l2h_pkg::GOLDEN_START;
                    c_next         = l2h_pkg::GOLDEN_START;
                    emit_next      = 1'b0;
                    step_next      = 4'd0;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= 4'd0;
            a_reg           <= l2h_pkg::GOLDEN_START;
            b_reg           <= l2h_pkg::GOLDEN_START;
            c_reg           <= l2h_pkg::GOLDEN_START;
            final_after_reg <= 1'b0;
            emit_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            c_reg           <= c_next;
            final_after_reg <= final_after_next;
            emit_reg        <= emit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        hash_reg <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

`ifndef SYNTHESIS
    a_pop_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == S_MIX && step_reg == 4'd0))
        else $error("mix core: command taken without starting a mix");

    a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && last_step && !final_after_reg && emit_reg && out_free)
        |=> (out_valid_reg && a_reg == l2h_pkg::GOLDEN_START
             && b_reg == l2h_pkg::GOLDEN_START && c_reg == l2h_pkg::GOLDEN_START))
        else $error("mix core: hash emitted without restarting key state");
`endif

endmodule

[hw/rtl/lookup2_string_hash.sv]
// ============================================================================
// lookup2_string_hash
// Streaming 32-bit lookup2 hash of a key delivered one byte per transaction.
// ============================================================================
// The block takes one key byte per cycle as long as its command queue has
// room. Every twelfth byte, and every key end, becomes one command for the
// mixing core, which adds the words and then runs the nine mix rounds, one
// round per cycle; when the key ends on the twelfth byte of a block it then
// adds the length and runs the nine rounds again. Long keys stream at one
// byte per cycle; a stream of short keys is paced by the mixing core. A
// transaction with byte_present low and last high ends the key without
// adding a byte (the empty key when no bytes came before); one with both low
// is ignored. The hash leaves through an output register, so the core keeps
// working while a result waits to be taken, up to the point where the next
// hash is ready.
// ============================================================================
module lookup2_string_hash #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    logic          queue_full;
    logic          queue_empty;
    logic          cmd_push;
    logic          cmd_pop;
    l2h_pkg::cmd_t push_cmd;
    l2h_pkg::cmd_t pop_cmd;

    l2h_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .queue_full   (queue_full),
        .cmd_push     (cmd_push),
        .cmd_data     (push_cmd)
    );

    l2h_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .pop_data  (pop_cmd),
        .empty     (queue_empty)
    );

    l2h_mix_core u_mix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!queue_empty),
        .cmd_data   (pop_cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule
